/* design/ellipse_vertex_generator_top_assert.svh */
// ----------------------------------------------------------------------------
// Ellipse vertex generator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define ELLIPSE_VERTEX_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define EVG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define EVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/evg_pkg.sv */
// ----------------------------------------------------------------------------
// evg_pkg
// Shared widths, register indexes and sine polynomial coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package evg_pkg;

  localparam int unsigned IdxW    = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned RadW    = 15;
  localparam int unsigned PhaseW  = 16;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned MagW    = 15;
  localparam int unsigned UW      = 31;   // Q30 value up to 1.0
  localparam int unsigned DivStg  = 8;
  localparam int unsigned BitsPerStg = PhaseW / DivStg;
  localparam int unsigned SinStg  = 6;

  localparam logic [1:0] RegRadiusX     = 2'd0;
  localparam logic [1:0] RegRadiusY     = 2'd1;
  localparam logic [1:0] RegVertexCount = 2'd2;

  localparam logic [UW-1:0] OneQ30 = UW'(32'd1 << 30);

  // Horner coefficients after the u^9 term: K7, K5, K3, K1
  localparam logic [UW-1:0] K9 = UW'(32'd172272);
  localparam logic [UW-1:0] KTab [4] = '{
    UW'(32'd5026995), UW'(32'd85569306), UW'(32'd693598668), UW'(32'd1686629713)
  };

endpackage

`default_nettype wire

/* design/evg_div.sv */
// ----------------------------------------------------------------------------
// evg_div
// Pipelined restoring divider: (idx << 16) / count, two quotient bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module evg_div (
  input  wire                            clk_i,
  input  wire [evg_pkg::DivStg-1:0]      en_i,
  input  wire [evg_pkg::IdxW-1:0]        idx_i,
  input  wire [evg_pkg::CountW-1:0]      count_i,
  output logic [evg_pkg::PhaseW-1:0]     quo_o
);

  logic [evg_pkg::CountW-1:0] rem_q [evg_pkg::DivStg];
  logic [evg_pkg::CountW-1:0] rem_d [evg_pkg::DivStg];
  logic [evg_pkg::PhaseW-1:0] quo_q [evg_pkg::DivStg];
  logic [evg_pkg::PhaseW-1:0] quo_d [evg_pkg::DivStg];

  always_comb begin
    logic [evg_pkg::CountW:0]   sh;
    logic [evg_pkg::CountW-1:0] r;
    logic [evg_pkg::PhaseW-1:0] q;
    for (int k = 0; k < int'(evg_pkg::DivStg); k++) begin
      if (k == 0) begin
        r = evg_pkg::CountW'(idx_i);
        q = '0;
      end else begin
        r = rem_q[k-1];
        q = quo_q[k-1];
      end
      for (int b = 0; b < int'(evg_pkg::BitsPerStg); b++) begin
        sh = {r, 1'b0};
        q  = {q[evg_pkg::PhaseW-2:0], 1'b0};
        if (sh >= {1'b0, count_i}) begin
          sh   = sh - {1'b0, count_i};
          q[0] = 1'b1;
        end
        r = sh[evg_pkg::CountW-1:0];
      end
      rem_d[k] = r;
      quo_d[k] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(evg_pkg::DivStg); k++) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[evg_pkg::DivStg-1];

endmodule

`default_nettype wire

/* design/evg_qsin.sv */
// ----------------------------------------------------------------------------
// evg_qsin
// Pipelined quarter sine sin(pi/2*u), u in Q30, Horner odd polynomial,
// result rounded to Q0.15 and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module evg_qsin (
  input  wire                           clk_i,
  input  wire [evg_pkg::SinStg-1:0]     en_i,
  input  wire [evg_pkg::UW-1:0]         u_i,
  output logic [evg_pkg::MagW-1:0]      mag_o
);

  localparam int unsigned UW = evg_pkg::UW;

  logic [UW-1:0] u_q  [5];
  logic [UW-1:0] u2_q [4];
  logic [UW-1:0] p_q  [4];
  logic [UW-1:0] p_d  [4];
  logic [UW-1:0] u2_d;
  logic [evg_pkg::MagW-1:0] mag_q, mag_d;

  always_comb begin
    logic [61:0] pr;
    logic [31:0] rnd;
    pr   = 62'(u_i) * 62'(u_i);
    u2_d = pr[60:30];
    pr     = 62'(evg_pkg::K9) * 62'(u2_q[0]);
    p_d[0] = evg_pkg::KTab[0] - pr[60:30];
    for (int k = 1; k < 4; k++) begin
      pr     = 62'(p_q[k-1]) * 62'(u2_q[k]);
      p_d[k] = evg_pkg::KTab[k] - pr[60:30];
    end
    pr  = 62'(p_q[3]) * 62'(u_q[4]);
    rnd = {1'b0, pr[60:30]} + 32'd16384;
    if (rnd[31:15] > 17'd32767) mag_d = 15'd32767;
    else                        mag_d = rnd[29:15];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u_q[0]  <= u_i;
      u2_q[0] <= u2_d;
    end
    for (int k = 0; k < 4; k++) begin
      if (en_i[k+1]) begin
        p_q[k]   <= p_d[k];
        u_q[k+1] <= u_q[k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (en_i[k+1]) u2_q[k+1] <= u2_q[k];
    end
    if (en_i[5]) mag_q <= mag_d;
  end

  assign mag_o = mag_q;

endmodule

`default_nettype wire

/* design/ellipse_vertex_generator_top.sv */
// ----------------------------------------------------------------------------
// ellipse_vertex_generator_top
// Vertex of an origin-centred ellipse outline for a given vertex index.
//
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata: vertex_index
// m_axis    out  tvalid/tready           tdata: vertex_x, vertex_y; tuser: index_valid
// cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One item per cycle while m_axis is not stalled; 17 register stages (input,
// 8 divider stages for the phase, 6 polynomial stages, scale and output).
// Reset clears valid bits and loads the register reset values.
// Each stage holds only when the next is full and stalled, so bubbles close up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ellipse_vertex_generator_top_assert.svh"

module ellipse_vertex_generator_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [1:0]           cfg_idx_i,
  input  wire [14:0]          cfg_data_i,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [15:0]          s_axis_tdata,   // [9:0] vertex_index
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [11:0] vertex_x, [23:12] vertex_y
  output logic                m_axis_tuser    // [0] index_valid
);

  localparam int unsigned NStg  = 17;
  localparam int unsigned SDiv  = 1;
  localparam int unsigned SSin  = SDiv + evg_pkg::DivStg;
  localparam int unsigned SMul  = SSin + evg_pkg::SinStg;
  localparam int unsigned SOut  = SMul + 1;

  logic [evg_pkg::RadW-1:0]   radius_x_q, radius_y_q;
  logic [evg_pkg::CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_x_q <= '0;
      radius_y_q <= '0;
      count_q    <= evg_pkg::CountW'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        evg_pkg::RegRadiusX:     radius_x_q <= cfg_data_i;
        evg_pkg::RegRadiusY:     radius_y_q <= cfg_data_i;
        evg_pkg::RegVertexCount: count_q    <= cfg_data_i[evg_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  logic [NStg-1:0] valid_q, en;
  logic            ok_q [NStg];
  logic [1:0]      quad_q [SSin:SMul-1];

  always_comb begin
    en[NStg-1] = !valid_q[NStg-1] || m_axis_tready;
    for (int k = NStg - 2; k >= 0; k--) en[k] = !valid_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < int'(NStg); k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  logic [evg_pkg::IdxW-1:0] idx_in, idx_q;
  assign idx_in = s_axis_tdata[evg_pkg::IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      idx_q    <= idx_in;
      ok_q[0]  <= (count_q != '0) && ({1'b0, idx_in} < count_q);
    end
    for (int k = 1; k < int'(NStg); k++) begin
      if (en[k]) ok_q[k] <= ok_q[k-1];
    end
  end

  logic [evg_pkg::PhaseW-1:0] phase;

  evg_div u_div (
    .clk_i   (clk_i),
    .en_i    (en[SDiv +: evg_pkg::DivStg]),
    .idx_i   (idx_q),
    .count_i (count_q),
    .quo_o   (phase)
  );

  logic [evg_pkg::UW-1:0] u_a, u_b;
  assign u_a = {1'b0, phase[13:0], 16'd0};
  assign u_b = evg_pkg::OneQ30 - u_a;

  always_ff @(posedge clk_i) begin
    if (en[SSin]) quad_q[SSin] <= phase[15:14];
    for (int k = SSin + 1; k < int'(SMul); k++) begin
      if (en[k]) quad_q[k] <= quad_q[k-1];
    end
  end

  logic [evg_pkg::MagW-1:0] sa, sb;

  evg_qsin u_sin_a (
    .clk_i (clk_i),
    .en_i  (en[SSin +: evg_pkg::SinStg]),
    .u_i   (u_a),
    .mag_o (sa)
  );

  evg_qsin u_sin_b (
    .clk_i (clk_i),
    .en_i  (en[SSin +: evg_pkg::SinStg]),
    .u_i   (u_b),
    .mag_o (sb)
  );

  logic [1:0]  qd;
  logic [29:0] px_q, py_q;
  logic        negx_q, negy_q;
  assign qd = quad_q[SMul-1];

  always_ff @(posedge clk_i) begin
    if (en[SMul]) begin
      px_q   <= 30'(radius_x_q) * 30'(qd[0] ? sa : sb);
      py_q   <= 30'(radius_y_q) * 30'(qd[0] ? sb : sa);
      negx_q <= qd[0] ^ qd[1];
      negy_q <= qd[1];
    end
  end

  logic [evg_pkg::CoordW-1:0] x_q, y_q, vx, vy;
  assign vx = {1'b0, px_q[29:19]};
  assign vy = {1'b0, py_q[29:19]};

  always_ff @(posedge clk_i) begin
    if (en[SOut]) begin
      x_q <= !ok_q[SMul] ? '0 : (negx_q ? -vx : vx);
      y_q <= !ok_q[SMul] ? '0 : (negy_q ? -vy : vy);
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NStg-1];
  assign m_axis_tdata  = {y_q, x_q};
  assign m_axis_tuser  = ok_q[NStg-1];

  `EVG_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  `EVG_ASSERT_NOW(a_ready_low_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  `EVG_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, valid_q[0])

endmodule

`default_nettype wire

/* dv/evg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse vertex checker
// Watches the config port and both item channels, predicts each vertex from
// the index and the current register values, and compares results in order.
// ----------------------------------------------------------------------------
module evg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [11:0] vx;
    logic [11:0] vy;
    logic        ok;
  } vertex_t;

  logic [14:0] rad_x, rad_y;
  logic [10:0] vcount;
  vertex_t     vertex_q[$];

  function automatic longint unsigned quarter_sine(longint unsigned u);
    longint unsigned u2, p, s;
    u2 = (u * u) >> 30;
    p = 172272;
    p = 5026995 - ((p * u2) >> 30);
    p = 85569306 - ((p * u2) >> 30);
    p = 693598668 - ((p * u2) >> 30);
    p = 1686629713 - ((p * u2) >> 30);
    s = (p * u) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 32767) s = 32767;
    return s;
  endfunction

  function automatic logic [11:0] scaled(longint unsigned r, longint unsigned m, bit neg);
    longint unsigned v;
    v = (r * m) >> 19;
    if (neg) v = 64'd0 - v;
    return v[11:0];
  endfunction

  function automatic vertex_t vertex_at(logic [9:0] idx);
    vertex_t         v;
    longint unsigned ph, f, sa, sb, sm, cm;
    logic [1:0]      quad;
    bit              sn, cn;
    v = '0;
    if (vcount == 0 || idx >= vcount) return v;
    ph = (longint'(idx) << 16) / vcount;
    quad = ph[15:14];
    f = longint'(ph[13:0]) << 16;
    sa = quarter_sine(f);
    sb = quarter_sine((64'd1 << 30) - f);
    case (quad)
      2'd0: begin sm = sa; sn = 0; cm = sb; cn = 0; end
      2'd1: begin sm = sb; sn = 0; cm = sa; cn = 1; end
      2'd2: begin sm = sa; sn = 1; cm = sb; cn = 1; end
      default: begin sm = sb; sn = 1; cm = sa; cn = 0; end
    endcase
    v.vx = scaled(rad_x, cm, cn);
    v.vy = scaled(rad_y, sm, sn);
    v.ok = 1'b1;
    return v;
  endfunction

  assign pending_o = vertex_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t e;
    int      n;
    if (!rst_ni) begin
      rad_x <= '0;
      rad_y <= '0;
      vcount <= 11'd64;
      errors_o <= 0;
      vertex_q.delete();
    end else begin
      n = 0;
      if (s_axis_tvalid && s_axis_tready) vertex_q.push_back(vertex_at(s_axis_tdata[9:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (vertex_q.size() == 0) begin
          $error("unexpected result item");
          n++;
        end else begin
          e = vertex_q.pop_front();
          if (m_axis_tdata[11:0] !== e.vx) begin
            $error("vertex_x exp %0d got %0d", $signed(e.vx), $signed(m_axis_tdata[11:0]));
            n++;
          end
          if (m_axis_tdata[23:12] !== e.vy) begin
            $error("vertex_y exp %0d got %0d", $signed(e.vy), $signed(m_axis_tdata[23:12]));
            n++;
          end
          if (m_axis_tuser !== e.ok) begin
            $error("index_valid exp %0b got %0b", e.ok, m_axis_tuser);
            n++;
          end
        end
      end
      if (n != 0) errors_o <= errors_o + n;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          evg_pkg::RegRadiusX:     rad_x <= cfg_data_i;
          evg_pkg::RegRadiusY:     rad_y <= cfg_data_i;
          evg_pkg::RegVertexCount: vcount <= cfg_data_i[10:0];
          default: ;
        endcase
      end
    end
  end
endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse vertex generator testbench
// Drives vertex indexes under several radius and count settings with random
// gaps and back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [14:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 0, s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
  logic [23:0] m_axis_tdata;
  int          errors, pending, cycles;
  bit          hold_rx = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  ellipse_vertex_generator_top u_top (.*);

  evg_checker u_chk (.*, .errors_o(errors), .pending_o(pending));

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_index(logic [9:0] idx);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'($urandom), idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic setup(logic [14:0] rx, logic [14:0] ry, logic [10:0] cnt);
    drain();
    write_reg(evg_pkg::RegRadiusX, rx);
    write_reg(evg_pkg::RegRadiusY, ry);
    write_reg(evg_pkg::RegVertexCount, {4'($urandom), cnt});
    cfg_we_i <= 0;
  endtask

  task automatic random_run(int n, int cnt);
    for (int i = 0; i < n; i++)
      send_index(10'($urandom_range(0, 99) < 85 && cnt > 0 ?
                 $urandom_range(0, cnt > 1024 ? 1023 : cnt - 1) : $urandom_range(0, 1023)));
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_rx && !held) begin
        held = 1;
        m_axis_tready <= 0;
        repeat (200) @(posedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int cnts[6] = '{1, 3, 7, 64, 1000, 1024};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // reset values: zero radii, 64 vertices
    send_index(0); send_index(63); send_index(64); send_index(1023);
    setup(15'h7fff, 15'h7fff, 11'd1024);
    send_index(0); send_index(256); send_index(512); send_index(768);
    send_index(1023); send_index(128); send_index(1);
    setup(15'h7fff, 15'd0, 11'd0);
    send_index(0); send_index(5);
    setup(15'd0, 15'h7fff, 11'd4);
    send_index(0); send_index(1); send_index(2); send_index(3); send_index(4);
    setup(15'h5555, 15'h2aaa, 11'd7);
    for (int i = 0; i < 8; i++) send_index(10'(i));
    // long receiver stall while items keep coming
    hold_rx = 1;
    random_run(60, 7);
    for (int p = 0; p < 12; p++) begin
      int c;
      c = (p < 6) ? cnts[p] : $urandom_range(1, 1024);
      setup(p == 1 ? 15'd0 : 15'($urandom), p == 2 ? 15'h7fff : 15'($urandom), 11'(c));
      random_run(55, c);
    end
    drain();
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
